@@ rtl/core/lpht_pkg.sv @@
`default_nettype none
package lpht_pkg;

  localparam int unsigned CAP_W   = 11;
  localparam int unsigned CAP_MIN = 16;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_LOOKUP = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_ZERO = 2'd2
  } status_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key_hash;
    logic [63:0] entry_offset;
  } in_req_t;

  typedef struct packed {
    logic        found;
    logic [63:0] result_offset;
    logic [1:0]  status;
  } out_rsp_t;

  // controller -> datapath
  typedef struct packed {
    logic load;       // capture request, start modulo
    logic mod_step;   // one restoring-division step
    logic rd;         // read slot at probe pointer
    logic wr;         // write slot at probe pointer
    logic advance;    // step probe pointer
    logic clr_start;  // reset clear pointer
    logic clr_step;   // zero one slot
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic mod_done;
    logic slot_empty;
    logic slot_match;
    logic probes_done;
    logic clr_done;
    logic key_zero;
  } dp_sts_t;

endpackage
`default_nettype wire

@@ rtl/core/lpht_dp.sv @@
`default_nettype none
module lpht_dp #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire lpht_pkg::in_req_t   req,
  input  wire [lpht_pkg::CAP_W-1:0] cap_reg,
  input  wire lpht_pkg::dp_cmd_t   cmd,
  output lpht_pkg::dp_sts_t        sts,
  output logic [63:0]              rd_offset
);
  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  logic [63:0] hash_mem [TABLE_DEPTH];
  logic [63:0] off_mem  [TABLE_DEPTH];

  logic [63:0] key_r, val_r, rd_hash_r, off_rd_r;
  logic [CW-1:0] cap_r, n_r, pos_r, rem_r;
  logic [6:0] bit_r;
  logic [AW-1:0] clr_r;
  logic clr_done_r;

  logic [CW-1:0] cap_eff;
  always_comb begin
    if (cap_reg < lpht_pkg::CAP_W'(lpht_pkg::CAP_MIN)) cap_eff = CW'(lpht_pkg::CAP_MIN);
    else if (32'(cap_reg) > TABLE_DEPTH) cap_eff = CW'(TABLE_DEPTH);
    else cap_eff = CW'(cap_reg);
  end

  // restoring remainder, one key bit per step, MSB first
  logic [CW:0] rem_sh;
  assign rem_sh = {rem_r, key_r[bit_r[5:0]]};

  logic [CW-1:0] rem_nxt;
  assign rem_nxt = (rem_sh >= {1'b0, cap_r}) ? CW'(rem_sh - {1'b0, cap_r}) : CW'(rem_sh);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r <= req.key_hash;
      val_r <= req.entry_offset;
      cap_r <= cap_eff;
      rem_r <= '0;
      bit_r <= 7'd63;
      n_r   <= '0;
    end else if (cmd.mod_step) begin
      rem_r <= rem_nxt;
      bit_r <= bit_r - 7'd1;
      if (bit_r == 7'd0) pos_r <= rem_nxt;
    end else if (cmd.advance) begin
      n_r <= n_r + CW'(1);
      if (pos_r + CW'(1) >= cap_r) pos_r <= '0;
      else pos_r <= pos_r + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) hash_mem[clr_r] <= '0;
    else if (cmd.wr) begin
      hash_mem[pos_r[AW-1:0]] <= key_r;
    end
    if (cmd.rd) rd_hash_r <= hash_mem[pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr) off_mem[pos_r[AW-1:0]] <= val_r;
    if (cmd.rd) off_rd_r <= off_mem[pos_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_start) begin
      clr_r      <= '0;
      clr_done_r <= 1'b0;
    end else if (cmd.clr_step) begin
      clr_r      <= clr_r + AW'(1);
      clr_done_r <= ({1'b0, clr_r} == (AW + 1)'(TABLE_DEPTH - 1));
    end
  end

  assign sts.mod_done    = (bit_r == 7'd0);
  assign sts.slot_empty  = (rd_hash_r == '0);
  assign sts.slot_match  = (rd_hash_r == key_r);
  assign sts.probes_done = (n_r == cap_r);
  assign sts.clr_done    = clr_done_r;
  assign sts.key_zero    = (req.key_hash == '0);
  assign rd_offset       = off_rd_r;
endmodule
`default_nettype wire

@@ rtl/core/lpht_ctrl.sv @@
`default_nettype none
module lpht_ctrl (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire                     start,
  input  wire lpht_pkg::in_req_t  req,
  input  wire lpht_pkg::dp_sts_t  sts,
  input  wire [63:0]              rd_offset,
  output logic                    busy,
  output lpht_pkg::dp_cmd_t       cmd,
  output logic                    out_valid,
  output lpht_pkg::out_rsp_t      out_rsp
);
  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_CHECK, S_READ, S_WAIT, S_CLEAR, S_INIT
  } state_t;

  state_t state_r;
  logic   is_ins_r;
  logic   out_valid_r;
  lpht_pkg::out_rsp_t rsp_r;

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_rsp   = rsp_r;

  logic go;
  assign go = start && !busy;

  always_comb begin
    cmd = '0;
    cmd.load      = go;
    cmd.clr_start = go && (req.cmd == lpht_pkg::CMD_CLEAR);
    unique case (state_r)
      S_MOD:   cmd.mod_step = 1'b1;
      S_READ:  cmd.rd = !sts.probes_done;
      S_CHECK: begin
        cmd.wr      = sts.slot_empty && is_ins_r;
        cmd.advance = !sts.slot_empty && !(sts.slot_match && !is_ins_r);
      end
      S_CLEAR: cmd.clr_step = !sts.clr_done;
      // table starts empty: one clearing pass after reset
      S_INIT:  cmd.clr_step = !sts.clr_done;
      default: ;
    endcase
  end

  // request finishes this cycle; response shows up next cycle
  logic done;
  always_comb begin
    done = 1'b0;
    unique case (state_r)
      S_IDLE:  done = go && ((req.cmd == lpht_pkg::CMD_NOP) ||
                             (req.cmd != lpht_pkg::CMD_CLEAR && sts.key_zero));
      S_READ:  done = sts.probes_done;
      S_CHECK: done = sts.slot_empty || (sts.slot_match && !is_ins_r);
      S_CLEAR: done = sts.clr_done;
      default: done = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      out_valid_r <= 1'b0;
      is_ins_r    <= 1'b0;
    end else begin
      out_valid_r <= done;
      unique case (state_r)
        S_IDLE: if (go) begin
          is_ins_r <= (req.cmd == lpht_pkg::CMD_INSERT);
          unique case (req.cmd) inside
            lpht_pkg::CMD_INSERT, lpht_pkg::CMD_LOOKUP: begin
              if (sts.key_zero) begin
                rsp_r <= '{found: 1'b0, result_offset: '0, status: lpht_pkg::ST_ZERO};
              end else begin
                rsp_r   <= '0;
                state_r <= S_MOD;
              end
            end
            lpht_pkg::CMD_CLEAR: begin
              rsp_r   <= '0;
              state_r <= S_CLEAR;
            end
            default: rsp_r <= '0;
          endcase
        end
        S_MOD: if (sts.mod_done) state_r <= S_READ;
        S_READ: begin
          if (sts.probes_done) begin
            rsp_r.status <= lpht_pkg::ST_FULL;
            state_r      <= S_IDLE;
          end else state_r <= S_WAIT;
        end
        S_WAIT: state_r <= S_CHECK;
        S_CHECK: begin
          if (sts.slot_empty) begin
            state_r <= S_IDLE;
          end else if (sts.slot_match && !is_ins_r) begin
            rsp_r.found         <= 1'b1;
            rsp_r.result_offset <= rd_offset;
            state_r             <= S_IDLE;
          end else state_r <= S_READ;
        end
        S_CLEAR: if (sts.clr_done) state_r <= S_IDLE;
        S_INIT:  if (sts.clr_done) state_r <= S_IDLE;
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/linear_probe_hash_table.sv @@
`default_nettype none
// Linear-probing hash table, one command per start pulse; busy is high while
// a command runs and the single result appears for one cycle on out_valid,
// which the receiver cannot stall. After reset busy stays high while every
// slot is emptied, one per cycle. Zero-hash or unused commands are answered
// from idle without probing; insert/lookup first form the bit-serial
// hash-mod-capacity remainder, then probe slot by slot (registered memory
// read), ending at an empty slot, a lookup match or the probe limit; clear
// zeroes one slot per cycle. Capacity saturates to [16, TABLE_DEPTH] and is
// captured when a command starts.
module linear_probe_hash_table #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire lpht_pkg::in_req_t    in_req,
  output logic                      out_valid,
  output lpht_pkg::out_rsp_t        out_rsp,
  input  wire                       cfg_we,
  input  wire [lpht_pkg::CAP_W-1:0] cfg_wdata
);
  logic [lpht_pkg::CAP_W-1:0] cap_r;
  lpht_pkg::dp_cmd_t dcmd;
  lpht_pkg::dp_sts_t dsts;
  logic [63:0] rd_offset;

  always_ff @(posedge clk) begin
    if (!rst_n) cap_r <= lpht_pkg::CAP_W'(16);
    else if (cfg_we) cap_r <= cfg_wdata;
  end

  lpht_dp #(.TABLE_DEPTH(TABLE_DEPTH)) u_dp (
    .clk(clk), .rst_n(rst_n), .req(in_req), .cap_reg(cap_r),
    .cmd(dcmd), .sts(dsts), .rd_offset(rd_offset)
  );

  lpht_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .req(in_req), .sts(dsts),
    .rd_offset(rd_offset), .busy(busy), .cmd(dcmd),
    .out_valid(out_valid), .out_rsp(out_rsp)
  );
endmodule
`default_nettype wire

@@ tb/lpht_checker.sv @@
`timescale 1ns / 1ps
module lpht_checker #(
  parameter int unsigned TABLE_DEPTH = 1024
) (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         start,
  input  wire                         busy,
  input  wire lpht_pkg::in_req_t      in_req,
  input  wire                         out_valid,
  input  wire lpht_pkg::out_rsp_t     out_rsp,
  input  wire                         cfg_we,
  input  wire [lpht_pkg::CAP_W-1:0]   cfg_wdata,
  output int                          errors,
  output int                          pending
);

  logic [63:0]                slot_key [TABLE_DEPTH];
  logic [63:0]                slot_val [TABLE_DEPTH];
  logic [lpht_pkg::CAP_W-1:0] cap_reg;
  lpht_pkg::out_rsp_t         rsp_q[$];

  // applies one request to the shadow table and returns its response
  function automatic lpht_pkg::out_rsp_t apply_request(lpht_pkg::in_req_t r);
    lpht_pkg::out_rsp_t o;
    int unsigned lim, pos, n;
    bit          stop;
    o = '0;
    lim = (cap_reg < lpht_pkg::CAP_MIN) ? lpht_pkg::CAP_MIN :
          ((cap_reg > TABLE_DEPTH) ? TABLE_DEPTH : cap_reg);
    case (lpht_pkg::cmd_t'(r.cmd)) inside
      lpht_pkg::CMD_CLEAR: begin
        for (int i = 0; i < TABLE_DEPTH; i++) slot_key[i] = '0;
      end
      lpht_pkg::CMD_INSERT, lpht_pkg::CMD_LOOKUP: begin
        if (r.key_hash == 64'd0) begin
          o.status = lpht_pkg::ST_ZERO;
        end else begin
          pos = 32'(r.key_hash % 64'(lim));
          o.status = lpht_pkg::ST_FULL;
          stop = 1'b0;
          for (n = 0; n < lim && !stop; n++) begin
            if (slot_key[pos] == 64'd0) begin
              if (lpht_pkg::cmd_t'(r.cmd) == lpht_pkg::CMD_INSERT) begin
                slot_key[pos] = r.key_hash;
                slot_val[pos] = r.entry_offset;
              end
              o.status = lpht_pkg::ST_OK;
              stop = 1'b1;
            end else if (lpht_pkg::cmd_t'(r.cmd) == lpht_pkg::CMD_LOOKUP &&
                         slot_key[pos] == r.key_hash) begin
              o.found = 1'b1;
              o.result_offset = slot_val[pos];
              o.status = lpht_pkg::ST_OK;
              stop = 1'b1;
            end else begin
              pos = (pos + 1 == lim) ? 0 : pos + 1;
            end
          end
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  initial begin
    errors = 0;
    pending = 0;
    cap_reg = 11'd16;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      slot_key[i] = '0;
      slot_val[i] = '0;
    end
  end

  always @(posedge clk) begin
    lpht_pkg::out_rsp_t e;
    if (!rst_n) begin
      cap_reg <= 11'd16;
      for (int i = 0; i < TABLE_DEPTH; i++) slot_key[i] = '0;
      rsp_q.delete();
    end else begin
      if (out_valid) begin
        if (rsp_q.size() == 0) begin
          $display("%0t: unexpected response %p", $time, out_rsp);
          errors <= errors + 1;
        end else begin
          e = rsp_q.pop_front();
          if (out_rsp.found !== e.found || out_rsp.result_offset !== e.result_offset ||
              out_rsp.status !== e.status) begin
            $display("%0t: mismatch expected found=%0b off=%h st=%0d, got found=%0b off=%h st=%0d",
                     $time, e.found, e.result_offset, e.status,
                     out_rsp.found, out_rsp.result_offset, out_rsp.status);
            errors <= errors + 1;
          end
        end
      end
      if (start && !busy) rsp_q = {rsp_q, apply_request(in_req)};
      if (cfg_we) cap_reg <= cfg_wdata;
    end
    pending <= rsp_q.size();
  end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
module tb;

  logic                       clk;
  logic                       rst_n;
  logic                       start;
  logic                       busy;
  lpht_pkg::in_req_t          in_req;
  logic                       out_valid;
  lpht_pkg::out_rsp_t         out_rsp;
  logic                       cfg_we;
  logic [lpht_pkg::CAP_W-1:0] cfg_wdata;
  int                         errors, pending;

  linear_probe_hash_table #(.TABLE_DEPTH(1024)) dut (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp, .cfg_we, .cfg_wdata
  );

  lpht_checker #(.TABLE_DEPTH(1024)) chk (
    .clk, .rst_n, .start, .busy, .in_req, .out_valid, .out_rsp, .cfg_we, .cfg_wdata,
    .errors, .pending
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #300ms;
    $display("CHECK FAILED");
    $finish;
  end

  task automatic send(lpht_pkg::cmd_t c, logic [63:0] k, logic [63:0] v);
    @(negedge clk);
    start <= 1'b1;
    in_req <= '{cmd: c, key_hash: k, entry_offset: v};
    do @(posedge clk); while (busy);
  endtask

  task automatic pause(int n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic drain();
    @(negedge clk);
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_capacity(logic [lpht_pkg::CAP_W-1:0] v);
    drain();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  int          phase_cap [8] = '{16, 0, 17, 100, 1024, 2047, 37, 16};
  int          phase_len [8] = '{200, 100, 150, 150, 60, 40, 150, 150};
  logic [63:0] key_pool [24];

  initial begin
    int             r;
    lpht_pkg::cmd_t c;
    logic [63:0]    k;
    start = 1'b0;
    in_req = '0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    rst_n = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero hash, unused command, fill one probe chain until full
    send(lpht_pkg::CMD_INSERT, 64'd0, rand64());
    send(lpht_pkg::CMD_LOOKUP, 64'd0, 64'd0);
    send(lpht_pkg::CMD_NOP, rand64(), rand64());
    send(lpht_pkg::CMD_INSERT, '1, '1);
    send(lpht_pkg::CMD_LOOKUP, '1, 64'd0);
    send(lpht_pkg::CMD_LOOKUP, 64'h13, 64'd0);      // miss at an empty slot
    send(lpht_pkg::CMD_INSERT, '1, 64'd7);          // duplicate, lookup keeps the first
    send(lpht_pkg::CMD_LOOKUP, '1, 64'd0);
    for (int i = 0; i < 14; i++) send(lpht_pkg::CMD_INSERT, 64'(i * 16 + 3), rand64());
    send(lpht_pkg::CMD_INSERT, 64'h55, 64'd1);      // no empty slot left
    send(lpht_pkg::CMD_LOOKUP, 64'h55, 64'd0);      // probe limit
    send(lpht_pkg::CMD_CLEAR, '0, '0);

    for (int p = 0; p < 8; p++) begin
      set_capacity(lpht_pkg::CAP_W'(phase_cap[p]));
      foreach (key_pool[i]) key_pool[i] = rand64();
      for (int i = 0; i < phase_len[p]; i++) begin
        if (p != 2 && $urandom_range(99) < 6) pause($urandom_range(1, 20));
        if (p == 3 && i == 75) drain();
        r = $urandom_range(99);
        k = ($urandom_range(9) < 7) ? key_pool[$urandom_range(23)] : rand64();
        if (r < 42)      c = lpht_pkg::CMD_INSERT;
        else if (r < 84) c = lpht_pkg::CMD_LOOKUP;
        else if (r < 86) c = lpht_pkg::CMD_CLEAR;
        else if (r < 92) begin
          c = (r & 1) ? lpht_pkg::CMD_INSERT : lpht_pkg::CMD_LOOKUP;
          k = '0;
        end
        else if (r < 95) c = lpht_pkg::CMD_NOP;
        else             c = lpht_pkg::CMD_LOOKUP;
        send(c, k, rand64());
      end
    end

    drain();
    repeat (3200) @(posedge clk);
    if (errors == 0 && pending == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
